FILE: rtl/vtafc_pkg.sv
// shared types, constants and angle table for the vector-to-angle unit
package vtafc_pkg;

   // width of the cordic x/y datapath: 32-bit input plus gain and sign headroom
   localparam int CORDIC_W = 35;

   // configuration port widths
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 23;

   // register widths
   localparam int LEN_EPS_W   = 16;
   localparam int ANG_EPS_W   = 10;
   localparam int ANGLE_W     = 23;
   localparam int EPS_SQ_W    = 33;

   // register reset values
   localparam logic [LEN_EPS_W-1:0] LEN_EPS_RESET   = 16'd0;
   localparam logic [ANG_EPS_W-1:0] ANG_EPS_RESET   = 10'd10;
   localparam logic [ANGLE_W-1:0]   FULL_TURN_RESET = 23'd6588397;

   // pi and pi/2 in q30
   localparam logic [31:0] Q30_PI      = 32'hC90FDAA2;
   localparam logic [31:0] Q30_HALF_PI = 32'h6487ED51;

   // atan(2^-i) in q30
   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   // register indexes on the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LENGTH_EPSILON,
      REG_ANGLE_EPSILON,
      REG_FULL_TURN
   } csr_reg_type;

   // control bits that travel with each request through the cordic pipe
   typedef struct packed {
      logic valid;
      logic y_neg;
   } side_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [ANG_EPS_W-1:0] angle_eps;
      logic [ANGLE_W-1:0]   full_turn;
      logic [EPS_SQ_W-1:0]  eps_sq;
   } cfg_type;

   // rescale a q30 angle to frac_bits fraction bits, rounding half up
   function automatic logic [31:0] rescale_q30(input logic [31:0] v, input int frac_bits);
      logic [32:0] w;
      int          sh;
      sh = 30 - frac_bits;
      w  = {1'b0, v};
      if (sh > 0) begin
         w = (w + (33'd1 << (sh - 1))) >> sh;
      end
      return w[31:0];
   endfunction

endpackage

FILE: rtl/vector_to_angle_full_circle_unit.sv
// top level: full-circle vector direction by pipelined cordic vectoring
//
// A request is a vector (req_x_value, req_y_value) in signed Q16.16, taken at
// each rising edge with start high and busy low. busy stays low, so a new
// request can enter in every cycle. The result rsp_angle is the direction in
// unsigned radians with ANGLE_FRAC_BITS fraction bits, in [0, full_turn) when
// full_turn exceeds pi, shown for one cycle with rsp_valid high once it has
// passed the request, start, cordic stage and response registers. Results
// leave in request order. Throughput is one vector per cycle, set by the
// cordic pipeline of one stage per iteration beside a four-stage length check.
// The receiver cannot stall: every result is shown once and counts as taken.
// Registers are written on the csr_ channel (always ready): 0 length epsilon,
// 1 angle epsilon, 2 full turn; other indexes are ignored. Write them only
// while no request is in flight.
// Reset empties the pipeline and loads the register reset values.
module vector_to_angle_full_circle_unit #(
   parameter int ANGLE_FRAC_BITS = 20,
   parameter int CORDIC_STAGES   = 22
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [31:0]                 req_x_value,
   input  logic signed [31:0]                 req_y_value,
   output logic                               rsp_valid,
   output logic [vtafc_pkg::ANGLE_W-1:0]      rsp_angle,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [vtafc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [vtafc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int W       = vtafc_pkg::CORDIC_W;
   localparam int ZW      = ANGLE_FRAC_BITS + 3;
   localparam int LEN_DLY = CORDIC_STAGES - 3;
   localparam logic signed [ZW-1:0] PI_Q =
      ZW'(vtafc_pkg::rescale_q30(vtafc_pkg::Q30_PI, ANGLE_FRAC_BITS));
   localparam logic signed [ZW-1:0] HALF_PI_Q =
      ZW'(vtafc_pkg::rescale_q30(vtafc_pkg::Q30_HALF_PI, ANGLE_FRAC_BITS));

   vtafc_pkg::cfg_type  cfg;

   logic                in_valid_ff;
   logic signed [31:0]  x_ff, y_ff;

   vtafc_pkg::side_type side_in;
   logic signed [W-1:0] x_ext, y_ext, ay_ext, cx_in, cy_in;
   logic signed [ZW-1:0] z_in;

   vtafc_pkg::side_type side_s [CORDIC_STAGES+1];
   logic signed [W-1:0]  cx_s   [CORDIC_STAGES+1];
   logic signed [W-1:0]  cy_s   [CORDIC_STAGES+1];
   logic signed [ZW-1:0] z_s    [CORDIC_STAGES+1];

   logic                len_valid, len_short;
   logic [LEN_DLY-1:0]  len_line_ff;

   logic signed [ZW-1:0]         z_last;
   logic [ZW-2:0]                t_clamp;
   logic [31:0]                  raw32;
   logic                         rsp_valid_ff;
   logic [vtafc_pkg::ANGLE_W-1:0] rsp_angle_ff, rsp_angle_in;

   assign busy = 1'b0;

   // configuration registers
   vtafc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= req_x_value;
      y_ff <= req_y_value;
   end

   // length check beside the cordic pipe
   vtafc_len u_len (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .x_value   (x_ff),
      .y_value   (y_ff),
      .eps_sq    (cfg.eps_sq),
      .out_valid (len_valid),
      .out_short (len_short)
   );

   // line up the length flag with the end of the cordic pipe
   always_ff @(posedge clock) begin
      len_line_ff <= {len_line_ff[LEN_DLY-2:0], len_short};
   end

   // cordic start: fold y to the upper half plane, left half rotated by pi/2
   always_comb begin
      x_ext  = W'(x_ff);
      y_ext  = W'(y_ff);
      ay_ext = y_ff[31] ? -y_ext : y_ext;
      if (x_ff[31]) begin
         cx_in = ay_ext;
         cy_in = -x_ext;
         z_in  = HALF_PI_Q;
      end else begin
         cx_in = x_ext;
         cy_in = ay_ext;
         z_in  = '0;
      end
      side_in.valid = in_valid_ff;
      side_in.y_neg = y_ff[31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_s[0].valid <= 1'b0;
      end else begin
         side_s[0].valid <= side_in.valid;
      end
      side_s[0].y_neg <= side_in.y_neg;
      cx_s[0]         <= cx_in;
      cy_s[0]         <= cy_in;
      z_s[0]          <= z_in;
   end

   // cordic stages
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      vtafc_cordic_stage #(
         .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
         .STAGE           (i)
      ) u_stage (
         .clock  (clock),
         .reset  (reset),
         .side_i (side_s[i]),
         .cx_i   (cx_s[i]),
         .cy_i   (cy_s[i]),
         .z_i    (z_s[i]),
         .side_o (side_s[i+1]),
         .cx_o   (cx_s[i+1]),
         .cy_o   (cy_s[i+1]),
         .z_o    (z_s[i+1])
      );
   end

   // clamp to [0, pi], thresholds and wrap for negative y
   always_comb begin
      z_last = z_s[CORDIC_STAGES];
      if (z_last[ZW-1]) begin
         t_clamp = '0;
      end else if (z_last > PI_Q) begin
         t_clamp = PI_Q[ZW-2:0];
      end else begin
         t_clamp = z_last[ZW-2:0];
      end
      raw32 = 32'(t_clamp);
      if (len_line_ff[LEN_DLY-1] || (raw32 <= 32'(cfg.angle_eps))) begin
         rsp_angle_in = '0;
      end else if (side_s[CORDIC_STAGES].y_neg) begin
         rsp_angle_in = cfg.full_turn - raw32[vtafc_pkg::ANGLE_W-1:0];
      end else begin
         rsp_angle_in = raw32[vtafc_pkg::ANGLE_W-1:0];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= side_s[CORDIC_STAGES].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_angle_ff <= rsp_angle_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_angle = rsp_angle_ff;

   // a finished cordic item is always answered next cycle
   a_last_to_rsp: assert property (@(posedge clock) disable iff (reset)
      side_s[CORDIC_STAGES].valid |=> rsp_valid)
      else $error("cordic output not answered");

   // every response comes from a request taken a fixed time earlier
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(in_valid_ff, CORDIC_STAGES + 2))
      else $error("response without matching request");

   // length check stays aligned with the cordic pipe
   a_len_align: assert property (@(posedge clock) disable iff (reset)
      len_valid == side_s[3].valid)
      else $error("length flag out of step with cordic pipe");

endmodule

FILE: rtl/vtafc_csr.sv
// configuration registers and derived squared length threshold
module vtafc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [vtafc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [vtafc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output vtafc_pkg::cfg_type                 cfg
);

   logic [vtafc_pkg::LEN_EPS_W-1:0] length_eps_ff, length_eps_in;
   logic [vtafc_pkg::ANG_EPS_W-1:0] angle_eps_ff, angle_eps_in;
   logic [vtafc_pkg::ANGLE_W-1:0]   full_turn_ff, full_turn_in;
   logic [vtafc_pkg::EPS_SQ_W-1:0]  eps_sq_ff, eps_sq_in;
   logic [vtafc_pkg::LEN_EPS_W:0]   eps_p1;
   logic [2*vtafc_pkg::LEN_EPS_W+1:0] eps_prod;

   // writes are always taken
   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      length_eps_in = length_eps_ff;
      angle_eps_in  = angle_eps_ff;
      full_turn_in  = full_turn_ff;
      if (csr_valid) begin
         unique case (csr_index)
            vtafc_pkg::REG_LENGTH_EPSILON: length_eps_in = csr_wdata[vtafc_pkg::LEN_EPS_W-1:0];
            vtafc_pkg::REG_ANGLE_EPSILON:  angle_eps_in  = csr_wdata[vtafc_pkg::ANG_EPS_W-1:0];
            vtafc_pkg::REG_FULL_TURN:      full_turn_in  = csr_wdata[vtafc_pkg::ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // length <= eps exactly when sum of squares < (eps+1)^2
   always_comb begin
      eps_p1    = {1'b0, length_eps_ff} + 17'd1;
      eps_prod  = eps_p1 * eps_p1;
      eps_sq_in = eps_prod[vtafc_pkg::EPS_SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_eps_ff <= vtafc_pkg::LEN_EPS_RESET;
         angle_eps_ff  <= vtafc_pkg::ANG_EPS_RESET;
         full_turn_ff  <= vtafc_pkg::FULL_TURN_RESET;
         eps_sq_ff     <= 33'd1;
      end else begin
         length_eps_ff <= length_eps_in;
         angle_eps_ff  <= angle_eps_in;
         full_turn_ff  <= full_turn_in;
         eps_sq_ff     <= eps_sq_in;
      end
   end

   assign cfg.angle_eps = angle_eps_ff;
   assign cfg.full_turn = full_turn_ff;
   assign cfg.eps_sq    = eps_sq_ff;

endmodule

FILE: rtl/vtafc_len.sv
// four-stage pipeline that tests the vector length against the threshold
module vtafc_len (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [31:0]                  x_value,
   input  logic signed [31:0]                  y_value,
   input  logic [vtafc_pkg::EPS_SQ_W-1:0]      eps_sq,
   output logic                                out_valid,
   output logic                                out_short
);

   logic [3:0]  valid_ff;
   logic [31:0] ax_ff, ay_ff, ax_in, ay_in;
   logic [63:0] x_sq_ff, y_sq_ff;
   logic [63:0] sum_ff;
   logic        short_ff, short_in;

   // magnitudes
   always_comb begin
      ax_in = x_value[31] ? (~x_value + 32'd1) : x_value;
      ay_in = y_value[31] ? (~y_value + 32'd1) : y_value;
   end

   // threshold compare on the squared length
   assign short_in = sum_ff < 64'(eps_sq);

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   // datapath: abs, square, sum, compare
   always_ff @(posedge clock) begin
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      x_sq_ff  <= ax_ff * ax_ff;
      y_sq_ff  <= ay_ff * ay_ff;
      sum_ff   <= x_sq_ff + y_sq_ff;
      short_ff <= short_in;
   end

   assign out_valid = valid_ff[3];
   assign out_short = short_ff;

endmodule

FILE: rtl/vtafc_cordic_stage.sv
// one registered cordic vectoring stage
module vtafc_cordic_stage #(
   parameter int ANGLE_FRAC_BITS = 20,
   parameter int STAGE           = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  vtafc_pkg::side_type                   side_i,
   input  logic signed [vtafc_pkg::CORDIC_W-1:0] cx_i,
   input  logic signed [vtafc_pkg::CORDIC_W-1:0] cy_i,
   input  logic signed [ANGLE_FRAC_BITS+2:0]     z_i,
   output vtafc_pkg::side_type                   side_o,
   output logic signed [vtafc_pkg::CORDIC_W-1:0] cx_o,
   output logic signed [vtafc_pkg::CORDIC_W-1:0] cy_o,
   output logic signed [ANGLE_FRAC_BITS+2:0]     z_o
);

   localparam int ZW = ANGLE_FRAC_BITS + 3;
   localparam logic [31:0] ATAN_RAW =
      vtafc_pkg::rescale_q30(vtafc_pkg::ATAN_Q30[STAGE], ANGLE_FRAC_BITS);
   localparam logic signed [ZW-1:0] ATAN_Q = ZW'(ATAN_RAW);

   vtafc_pkg::side_type                   side_ff;
   logic signed [vtafc_pkg::CORDIC_W-1:0] cx_ff, cy_ff, cx_in, cy_in, dx, dy;
   logic signed [ZW-1:0]                  z_ff, z_in;

   // rotate toward the x axis by the sign of y
   always_comb begin
      dx = cy_i >>> STAGE;
      dy = cx_i >>> STAGE;
      if (!cy_i[vtafc_pkg::CORDIC_W-1]) begin
         cx_in = cx_i + dx;
         cy_in = cy_i - dy;
         z_in  = z_i + ATAN_Q;
      end else begin
         cx_in = cx_i - dx;
         cy_in = cy_i + dy;
         z_in  = z_i - ATAN_Q;
      end
   end

   // valid and sign travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else begin
         side_ff.valid <= side_i.valid;
      end
      side_ff.y_neg <= side_i.y_neg;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      z_ff          <= z_in;
   end

   assign side_o = side_ff;
   assign cx_o   = cx_ff;
   assign cy_o   = cy_ff;
   assign z_o    = z_ff;

endmodule

FILE: tb/vector_angle_checker.sv
// checker for the vector-to-angle unit: predicts each angle and compares it with the result
`timescale 1ns / 100ps

module vector_angle_checker #(
   parameter int ANGLE_FRAC_BITS = 20,
   parameter int CORDIC_STAGES   = 22
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic signed [31:0]                   req_x_value,
   input  logic signed [31:0]                   req_y_value,
   input  logic                                 rsp_valid,
   input  logic [vtafc_pkg::ANGLE_W-1:0]        rsp_angle,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [vtafc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vtafc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                 check_done,
   output int                                   angle_errors,
   output int                                   in_flight,
   output int                                   angles_checked,
   output int                                   zero_angles
);

   // atan(2^-i) in q30
   localparam logic [31:0] ARCTAN_Q30 [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };
   localparam logic [31:0] PI_Q30      = 32'hC90FDAA2;
   localparam logic [31:0] HALF_PI_Q30 = 32'h6487ED51;

   typedef struct {
      logic signed [31:0]                 x;
      logic signed [31:0]                 y;
      logic [vtafc_pkg::ANGLE_W-1:0]      angle;
   } vector_angle_type;

   // angles still owed by the unit, oldest first
   vector_angle_type pending_angles [$];

   // shadow copies of the registers
   logic [vtafc_pkg::LEN_EPS_W-1:0] len_eps;
   logic [vtafc_pkg::ANG_EPS_W-1:0] ang_eps;
   logic [vtafc_pkg::ANGLE_W-1:0]   turn;
   bit                              leftovers_reported;

   // q30 angle to the output scale, half an lsb added before the shift
   function automatic longint to_angle_units(input logic [31:0] q30);
      int sh;
      sh = 30 - ANGLE_FRAC_BITS;
      if (sh <= 0) begin
         return longint'({32'd0, q30});
      end
      return longint'(({32'd0, q30} + (64'd1 << (sh - 1))) >> sh);
   endfunction

   // direction of (x, y), in [0, turn) when turn exceeds pi, zero for short vectors and tiny raw angles
   function automatic logic [vtafc_pkg::ANGLE_W-1:0] direction_of(
         input logic signed [31:0] x, input logic signed [31:0] y);
      longint      xs, ys, cx, cy, z, dx, dy, pi_units, clamped;
      logic [63:0] ax, ay, rem, root, probe;
      logic [vtafc_pkg::ANGLE_W-1:0] raw;
      int          stage;
      xs = x;
      ys = y;
      ax = (xs < 0) ? -xs : xs;
      ay = (ys < 0) ? -ys : ys;

      // exact floor square root of x*x + y*y
      rem   = ax * ax + ay * ay;
      root  = 64'd0;
      probe = 64'd1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 64'd0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      if (root <= {48'd0, len_eps}) return '0;

      // rotate the left half plane into the right one first
      cx = xs;
      cy = longint'(ay);
      z  = 0;
      if (xs < 0) begin
         cx = longint'(ay);
         cy = -xs;
         z  = to_angle_units(HALF_PI_Q30);
      end

      // cordic vectoring toward y = 0
      for (stage = 0; stage < CORDIC_STAGES; stage++) begin
         dx = cy >>> stage;
         dy = cx >>> stage;
         if (cy >= 0) begin
            cx = cx + dx;
            cy = cy - dy;
            z  = z + to_angle_units(ARCTAN_Q30[stage]);
         end else begin
            cx = cx - dx;
            cy = cy + dy;
            z  = z - to_angle_units(ARCTAN_Q30[stage]);
         end
      end

      // clamp to [0, pi], then threshold and wrap for negative y
      pi_units = to_angle_units(PI_Q30);
      clamped  = (z < 0) ? 0 : ((z > pi_units) ? pi_units : z);
      if (clamped <= longint'({54'd0, ang_eps})) return '0;
      raw = clamped[vtafc_pkg::ANGLE_W-1:0];
      if (ys < 0) return turn - raw;
      return raw;
   endfunction

   // count a failure, print only the first ten
   task record_error(input string what);
      if (angle_errors < 10) $display("mismatch: %s", what);
      angle_errors++;
   endtask

   always @(posedge clock) begin
      vector_angle_type oldest;
      vector_angle_type fresh;
      if (reset) begin
         pending_angles.delete();
         len_eps            = vtafc_pkg::LEN_EPS_RESET;
         ang_eps            = vtafc_pkg::ANG_EPS_RESET;
         turn               = vtafc_pkg::FULL_TURN_RESET;
         angle_errors       = 0;
         angles_checked     = 0;
         zero_angles        = 0;
         leftovers_reported = 1'b0;
         in_flight         <= 0;
      end else begin
         // compare a shown result with the oldest owed angle
         if (rsp_valid) begin
            if (pending_angles.size() == 0) begin
               record_error($sformatf("angle %0d shown with no request waiting", rsp_angle));
            end else begin
               oldest = pending_angles.pop_front();
               angles_checked++;
               if (rsp_angle !== oldest.angle) begin
                  record_error($sformatf("x=%0d y=%0d expected angle %0d, got %0d",
                                         oldest.x, oldest.y, oldest.angle, rsp_angle));
               end
            end
         end

         // predict the angle of an accepted request
         if (start && !busy) begin
            fresh.x     = req_x_value;
            fresh.y     = req_y_value;
            fresh.angle = direction_of(req_x_value, req_y_value);
            if (fresh.angle == '0) zero_angles++;
            pending_angles.push_back(fresh);
         end

         // follow register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               vtafc_pkg::REG_LENGTH_EPSILON:
                  len_eps = csr_wdata[vtafc_pkg::LEN_EPS_W-1:0];
               vtafc_pkg::REG_ANGLE_EPSILON:
                  ang_eps = csr_wdata[vtafc_pkg::ANG_EPS_W-1:0];
               vtafc_pkg::REG_FULL_TURN:
                  turn    = csr_wdata[vtafc_pkg::ANGLE_W-1:0];
               default: ;
            endcase
         end

         // angles never delivered by the end of the run
         if (check_done && !leftovers_reported) begin
            leftovers_reported = 1'b1;
            if (pending_angles.size() != 0) begin
               $display("mismatch: %0d requests never got an angle", pending_angles.size());
               angle_errors = angle_errors + pending_angles.size();
            end
         end

         in_flight <= pending_angles.size();
      end
   end

endmodule

FILE: tb/vector_to_angle_full_circle_unit_tb.sv
// testbench top for the vector-to-angle unit: reset, register settings and vector stimulus
`timescale 1ns / 100ps

module vector_to_angle_full_circle_unit_tb;

   localparam int ANGLE_FRAC_BITS = 20;
   localparam int CORDIC_STAGES   = 22;
   localparam int SETTLE_CYCLES   = CORDIC_STAGES + 6;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int PHASE_REQUESTS  = 81;

   // index past the register list, must be ignored
   localparam logic [vtafc_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

   localparam logic signed [31:0] X_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] X_MIN = 32'sh8000_0000;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic signed [31:0]                   req_x_value;
   logic signed [31:0]                   req_y_value;
   logic                                 rsp_valid;
   logic [vtafc_pkg::ANGLE_W-1:0]        rsp_angle;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [vtafc_pkg::CSR_INDEX_W-1:0]    csr_index;
   logic [vtafc_pkg::CSR_DATA_W-1:0]     csr_wdata;
   logic                                 check_done;

   int angle_errors;
   int in_flight;
   int angles_checked;
   int zero_angles;
   int requests_sent  = 0;
   int settings_count = 1;
   int cycle_count    = 0;

   vector_to_angle_full_circle_unit #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_STAGES   (CORDIC_STAGES)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_x_value (req_x_value),
      .req_y_value (req_y_value),
      .rsp_valid   (rsp_valid),
      .rsp_angle   (rsp_angle),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   vector_angle_checker #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_STAGES   (CORDIC_STAGES)
   ) angle_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_x_value    (req_x_value),
      .req_y_value    (req_y_value),
      .rsp_valid      (rsp_valid),
      .rsp_angle      (rsp_angle),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .check_done     (check_done),
      .angle_errors   (angle_errors),
      .in_flight      (in_flight),
      .angles_checked (angles_checked),
      .zero_angles    (zero_angles)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop for a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("run stopped at the cycle limit with %0d angles owed", in_flight);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // present one request and hold it until taken
   task automatic send_vector(input logic signed [31:0] x, input logic signed [31:0] y);
      start       <= 1'b1;
      req_x_value <= x;
      req_y_value <= y;
      @(posedge clock);
      while (busy) @(posedge clock);
      requests_sent++;
   endtask

   // stop sending and wait until every owed angle has come out
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write, valid left high for a following write
   task automatic write_reg(input logic [vtafc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [vtafc_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // drain, then load all three registers, the two epsilons with junk above their widths
   task automatic change_settings(input logic [vtafc_pkg::LEN_EPS_W-1:0] le,
                                  input logic [vtafc_pkg::ANG_EPS_W-1:0] ae,
                                  input logic [vtafc_pkg::ANGLE_W-1:0]   ft,
                                  input bit                              poke_unmapped);
      logic [31:0] junk;
      wait_drained();
      junk = $urandom;
      write_reg(vtafc_pkg::REG_FULL_TURN, ft);
      if (poke_unmapped) write_reg(REG_UNMAPPED, junk[22:0]);
      write_reg(vtafc_pkg::REG_ANGLE_EPSILON, {junk[12:0], ae});
      write_reg(vtafc_pkg::REG_LENGTH_EPSILON, {junk[28:22], le});
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   function automatic logic signed [31:0] spread(input int reach);
      return int'($urandom_range(0, 2 * reach)) - reach;
   endfunction

   function automatic logic signed [31:0] pick_extreme();
      case ($urandom_range(0, 5))
         0:       return 32'sd0;
         1:       return 32'sd1;
         2:       return -32'sd1;
         3:       return X_MAX;
         4:       return X_MIN;
         default: return 32'sh0001_0000;
      endcase
   endfunction

   // random vector drawn from a mix of shapes
   task automatic make_vector(output logic signed [31:0] x, output logic signed [31:0] y);
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            x = $urandom;
            y = $urandom;
         end
         3: begin
            x = spread(1 << 17);
            y = spread(1 << 17);
         end
         // just off the positive x axis, tiny raw angle either side
         4: begin
            x = $urandom_range(32'h0010_0000, 32'h7FFF_FFFF);
            y = spread(4096);
         end
         // near the negative x axis, y within 64 of zero
         5: begin
            x = -int'($urandom_range(32'h0010_0000, 32'h7FFF_FFFF));
            y = spread(64);
         end
         6: begin
            x = pick_extreme();
            y = pick_extreme();
         end
         // lengths around the length threshold range
         7: begin
            x = spread(80000);
            y = spread(80000);
         end
         8: begin
            x = $urandom;
            y = $urandom;
            if ($urandom_range(0, 1)) x = 32'sd0;
            else y = 32'sd0;
         end
         default: begin
            x = $urandom;
            y = $urandom_range(0, 1) ? x : -x;
         end
      endcase
   endtask

   // random requests in bursts with gaps of random length
   task automatic run_batch(input int count);
      logic signed [31:0] x, y;
      int burst, gap, n;
      burst = 0;
      for (n = 0; n < count; n++) begin
         if (burst == 0) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            gap   = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         make_vector(x, y);
         send_vector(x, y);
         burst--;
      end
   endtask

   initial begin
      logic [31:0] r;
      reset       = 1'b1;
      start       = 1'b0;
      req_x_value = '0;
      req_y_value = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      check_done  = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed vectors under the reset settings
      send_vector(32'sd0, 32'sd0);
      send_vector(32'sd1, 32'sd0);
      send_vector(32'sd0, 32'sd1);
      send_vector(-32'sd1, 32'sd0);
      send_vector(32'sd0, -32'sd1);
      send_vector(X_MAX, 32'sd0);
      send_vector(X_MIN, 32'sd0);
      send_vector(32'sd0, X_MAX);
      send_vector(32'sd0, X_MIN);
      send_vector(X_MAX, X_MAX);
      send_vector(X_MIN, X_MIN);
      send_vector(X_MIN, X_MAX);
      send_vector(X_MAX, X_MIN);
      // zero y with negative x stays near pi
      send_vector(-32'sd65536, 32'sd0);
      send_vector(32'sd65536, 32'sd65536);
      send_vector(-32'sd65536, -32'sd65536);
      // raw angle under the angle threshold, with y of either sign
      send_vector(X_MAX, 32'sd5);
      send_vector(X_MAX, -32'sd5);
      // raw angle just over the threshold with negative y wraps near full turn
      send_vector(32'sh4000_0000, -32'sd21475);
      send_vector(32'sd3, -32'sd4);
      send_vector(-32'sd2, -32'sd1);

      run_batch(PHASE_REQUESTS);

      // all zero, full turn wraps for every negative y
      change_settings(16'd0, 10'd0, 23'd0, 1'b1);
      run_batch(PHASE_REQUESTS);

      // all at maximum, with a full drain in the middle
      change_settings(16'hFFFF, 10'h3FF, 23'h7F_FFFF, 1'b0);
      run_batch(PHASE_REQUESTS / 2);
      wait_drained();
      run_batch(PHASE_REQUESTS - PHASE_REQUESTS / 2);

      r = $urandom;
      change_settings(r[15:0], r[25:16], 23'($urandom_range(0, 23'h7F_FFFF)), 1'b0);
      run_batch(PHASE_REQUESTS);

      change_settings(16'd1, 10'd1, vtafc_pkg::FULL_TURN_RESET, 1'b0);
      run_batch(PHASE_REQUESTS);

      // full turn below most raw angles
      change_settings(16'd0, 10'd10, 23'd1000, 1'b0);
      run_batch(PHASE_REQUESTS);

      r = $urandom;
      change_settings(r[31:16], r[9:0],
                      23'($urandom_range(23'd6000000, 23'd7000000)), 1'b1);
      run_batch(PHASE_REQUESTS);

      change_settings(vtafc_pkg::LEN_EPS_RESET, vtafc_pkg::ANG_EPS_RESET,
                      vtafc_pkg::FULL_TURN_RESET, 1'b0);
      run_batch(PHASE_REQUESTS);

      // final drain and check for angles never delivered
      wait_drained();
      check_done <= 1'b1;
      repeat (2) @(posedge clock);

      $display("covered %0d vectors under %0d register settings", requests_sent, settings_count);
      $display("%0d angles compared, %0d of them expected zero, %0d failures",
               angles_checked, zero_angles, angle_errors);
      if (angle_errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
